/* hdl/two_coil_fire_sequencer_assert.svh */
// Assertion macros shared by the fire sequencer modules.
`ifndef TWO_COIL_FIRE_SEQUENCER_ASSERT_SVH
`define TWO_COIL_FIRE_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset.
`define TCFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tcfs assertion failed");

// Expression is never true outside reset.
`define TCFS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tcfs forbidden condition");

`else

`define TCFS_ASSERT(label, clk, rst_n, prop)
`define TCFS_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* hdl/tcfs_pkg.sv */
`timescale 1ns / 1ps

package tcfs_pkg;

    typedef struct packed {
        logic [2:0] cmd;
        logic       stage_level;
    } tcfs_in_t;

    typedef struct packed {
        logic coil1_on;
        logic coil2_on;
        logic sensor_on;
        logic firing;
        logic locked_out;
    } tcfs_out_t;

    typedef struct packed {
        logic [7:0]  coil_on_ticks;
        logic [15:0] lockout_ticks;
        logic [7:0]  debounce_high_limit;
        logic [7:0]  settle_limit;
    } tcfs_cfg_t;

    // Result handed from the control core to the output buffer
    typedef struct packed {
        logic      push;
        tcfs_out_t data;
    } tcfs_res_t;

    localparam logic [2:0] CMD_STAGE_EDGE = 3'd0;
    localparam logic [2:0] CMD_POLL       = 3'd1;
    localparam logic [2:0] CMD_COMP_TRIP  = 3'd2;
    localparam logic [2:0] CMD_SLOW_TICK  = 3'd3;
    localparam logic [2:0] CMD_FAST_TICK  = 3'd4;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COIL_ON_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIMIT  = 2'd3;

    localparam logic [7:0]  RST_COIL_ON_TICKS = 8'd6;
    localparam logic [15:0] RST_LOCKOUT_TICKS = 16'd20;
    localparam logic [7:0]  RST_DEBOUNCE_HIGH = 8'd5;
    localparam logic [7:0]  RST_SETTLE_LIMIT  = 8'd15;

endpackage

/* hdl/tcfs_ctrl.sv */
`timescale 1ns / 1ps

`include "two_coil_fire_sequencer_assert.svh"

module tcfs_ctrl
    import tcfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  tcfs_in_t  item,
    input  tcfs_cfg_t cfg,
    output tcfs_res_t res
);

    logic        armed_reg, armed_next;
    logic [7:0]  high_run_reg, high_run_next;
    logic [7:0]  settle_run_reg, settle_run_next;
    logic        in_seq_reg, in_seq_next;
    logic        comp_ready_reg, comp_ready_next;
    logic [7:0]  timeout_reg, timeout_next;
    logic [15:0] lockout_reg, lockout_next;
    logic        coil1_reg, coil1_next;
    logic        coil2_reg, coil2_next;
    logic        sensor_reg, sensor_next;

    logic [7:0]  settle_inc;
    logic [7:0]  high_upd;
    logic        fire;

    always_comb
    begin
        armed_next      = armed_reg;
        high_run_next   = high_run_reg;
        settle_run_next = settle_run_reg;
        in_seq_next     = in_seq_reg;
        comp_ready_next = comp_ready_reg;
        timeout_next    = timeout_reg;
        lockout_next    = lockout_reg;
        coil1_next      = coil1_reg;
        coil2_next      = coil2_reg;
        sensor_next     = sensor_reg;

        settle_inc = (settle_run_reg == 8'hFF) ? settle_run_reg : settle_run_reg + 8'd1;
        if (item.stage_level)
        begin
            high_upd = (high_run_reg == 8'hFF) ? high_run_reg : high_run_reg + 8'd1;
        end
        else
        begin
            high_upd = 8'd0;
        end
        fire = high_upd > cfg.debounce_high_limit;

        case (item.cmd)
            CMD_STAGE_EDGE:
            begin
                if (lockout_reg == 16'd0 && !in_seq_reg)
                begin
                    settle_run_next = 8'd0;
                    armed_next      = 1'b1;
                    sensor_next     = 1'b1;
                end
            end
            CMD_POLL:
            begin
                if (armed_reg)
                begin
                    settle_run_next = settle_inc;
                    high_run_next   = high_upd;
                    // firing disarms first, so settle expiry cannot follow
                    if (fire)
                    begin
                        coil1_next      = 1'b1;
                        in_seq_next     = 1'b1;
                        timeout_next    = cfg.coil_on_ticks;
                        armed_next      = 1'b0;
                        high_run_next   = 8'd0;
                        settle_run_next = 8'd0;
                    end
                    else if (settle_inc > cfg.settle_limit)
                    begin
                        sensor_next     = 1'b0;
                        armed_next      = 1'b0;
                        high_run_next   = 8'd0;
                        settle_run_next = 8'd0;
                    end
                end
            end
            CMD_COMP_TRIP:
            begin
                if (comp_ready_reg)
                begin
                    coil1_next   = 1'b0;
                    coil2_next   = 1'b1;
                    timeout_next = cfg.coil_on_ticks;
                end
            end
            CMD_SLOW_TICK:
            begin
                if (in_seq_reg)
                begin
                    comp_ready_next = 1'b1;
                    if (timeout_reg == 8'd1)
                    begin
                        coil1_next      = 1'b0;
                        coil2_next      = 1'b0;
                        comp_ready_next = 1'b0;
                        lockout_next    = cfg.lockout_ticks;
                        timeout_next    = 8'd0;
                        in_seq_next     = 1'b0;
                    end
                    else if (timeout_reg != 8'd0)
                    begin
                        timeout_next = timeout_reg - 8'd1;
                    end
                end
            end
            CMD_FAST_TICK:
            begin
                if (lockout_reg == 16'd1)
                begin
                    coil1_next   = 1'b0;
                    coil2_next   = 1'b0;
                    lockout_next = 16'd0;
                end
                else if (lockout_reg != 16'd0)
                begin
                    lockout_next = lockout_reg - 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            high_run_reg   <= 8'd0;
            settle_run_reg <= 8'd0;
            in_seq_reg     <= 1'b0;
            comp_ready_reg <= 1'b0;
            timeout_reg    <= RST_COIL_ON_TICKS;
            lockout_reg    <= 16'd0;
            coil1_reg      <= 1'b0;
            coil2_reg      <= 1'b0;
            sensor_reg     <= 1'b0;
        end
        else if (accept)
        begin
            armed_reg      <= armed_next;
            high_run_reg   <= high_run_next;
            settle_run_reg <= settle_run_next;
            in_seq_reg     <= in_seq_next;
            comp_ready_reg <= comp_ready_next;
            timeout_reg    <= timeout_next;
            lockout_reg    <= lockout_next;
            coil1_reg      <= coil1_next;
            coil2_reg      <= coil2_next;
            sensor_reg     <= sensor_next;
        end
    end

    // Result is the state after the transaction
    assign res.push            = accept;
    assign res.data.coil1_on   = coil1_next;
    assign res.data.coil2_on   = coil2_next;
    assign res.data.sensor_on  = sensor_next;
    assign res.data.firing     = in_seq_next;
    assign res.data.locked_out = lockout_next != 16'd0;

    `TCFS_ASSERT_NEVER(a_coils_exclusive, clk, rst_n, coil1_reg && coil2_reg)
    `TCFS_ASSERT_NEVER(a_armed_not_firing, clk, rst_n, armed_reg && in_seq_reg)
    `TCFS_ASSERT(a_no_lockout_in_seq, clk, rst_n, in_seq_reg |-> lockout_reg == 16'd0)
    `TCFS_ASSERT(a_ready_in_seq, clk, rst_n, comp_ready_reg |-> in_seq_reg)

endmodule

/* hdl/tcfs_out_buf.sv */
`timescale 1ns / 1ps

`include "two_coil_fire_sequencer_assert.svh"

module tcfs_out_buf
    import tcfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tcfs_res_t res,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output tcfs_out_t out_data
);

    tcfs_out_t  mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != 2'd0;
    assign space     = count_reg != 2'd2;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = res.push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, res.push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            mem[wr_ptr_reg] <= res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TCFS_ASSERT_NEVER(a_no_overflow, clk, rst_n, res.push && !space)
    `TCFS_ASSERT(a_ptr_track, clk, rst_n,
                 (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
    `TCFS_ASSERT(a_push_shows, clk, rst_n, res.push |=> out_valid)

endmodule

/* hdl/two_coil_fire_sequencer.sv */
`timescale 1ns / 1ps

// Two-coil fire sequencer. Each input transaction is one event (stage edge,
// poll sample, comparator trip, slow tick, fast tick) and yields exactly one
// result transaction carrying the coil, sensor, firing and lockout flags as
// they stand after that event. One event is taken per clock: the whole state
// update is a single pass of counter and flag logic, and results queue in a
// two-entry output buffer, so in_ready drops only when that buffer is full.
// Results are registered in the buffer and shown in order of acceptance.
// Configuration writes take effect on the next event and should be made only
// while no events are in flight.

module two_coil_fire_sequencer
    import tcfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tcfs_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tcfs_out_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tcfs_cfg_t cfg_reg;
    tcfs_res_t res;
    logic      accept;
    logic      space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coil_on_ticks       <= RST_COIL_ON_TICKS;
            cfg_reg.lockout_ticks       <= RST_LOCKOUT_TICKS;
            cfg_reg.debounce_high_limit <= RST_DEBOUNCE_HIGH;
            cfg_reg.settle_limit        <= RST_SETTLE_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COIL_ON_TICKS: cfg_reg.coil_on_ticks       <= cfg_data[7:0];
                CFG_LOCKOUT_TICKS: cfg_reg.lockout_ticks       <= cfg_data;
                CFG_DEBOUNCE_HIGH: cfg_reg.debounce_high_limit <= cfg_data[7:0];
                CFG_SETTLE_LIMIT:  cfg_reg.settle_limit        <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = space;
    assign accept   = in_valid && space;

    tcfs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .res    (res)
    );

    tcfs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
